// File: rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, register indexes and twiddle constant functions for the
// radix-2 complex FFT.
// ----------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

    // Configuration register indexes
    localparam logic CFG_LOG_SIZE  = 1'b0;
    localparam logic CFG_DIRECTION = 1'b1;

    // Input kinds carried on tuser
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UNLOAD = 1'b1;

    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 32;
    localparam int TW_BITS  = 19;   // Q1.17 plus sign, holds +1.0
    localparam int TW_FRAC  = 17;

    localparam real PI_VALUE = 3.14159265358979323846;

    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [TW_BITS-1:0] twiddle_t;

    // Round to nearest in Q1.17, ties away from zero
    function automatic twiddle_t round_q17(input real v);
        real scaled;
        int  mag;
        scaled = v * 131072.0;
        if (scaled >= 0.0) begin
            mag = $rtoi(scaled + 0.5);
            return TW_BITS'(mag);
        end else begin
            mag = $rtoi(0.5 - scaled);
            return TW_BITS'(-mag);
        end
    endfunction

    // Twiddle k of a table whose angle step is given in radians
    function automatic twiddle_t twiddle_cos(input real step, input int k);
        real theta;
        theta = step * k;
        return round_q17($cos(theta));
    endfunction

    function automatic twiddle_t twiddle_sin(input real step, input int k);
        real theta;
        theta = step * k;
        return round_q17($sin(theta));
    endfunction

endpackage

`default_nettype wire

// File: rtl/radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time FFT around one sample memory.
// ----------------------------------------------------------------------------
// Load transaction: a single memory write. Unload transaction: a registered
// memory read then the output register; the next unload is taken once it lands.
// Final load: bit reversal visits each index, a swap going through RD_A, RD_B,
// MUL, WR_A and WR_B, then log_size stages of n/2 butterflies through RD_A to
// WR_B, all on the single memory port pair; no transaction is accepted meanwhile.
// Reset (aresetn, synchronous) clears pointers and control and sets log_size to
// 10 and direction to 0; the sample memory is not cleared and is undefined until written.
`default_nettype none

module radix2_complex_fft #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] sample_re, [31:16] sample_im
    input  wire logic        s_tuser,   // [0] mode
    input  wire logic        s_tlast,   // final_sample
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] result_re, [63:32] result_im
    output logic             m_tlast    // final_result
);

    localparam int CAP_LOG = $clog2(MAX_POINTS + 1) - 1;
    localparam int CAP     = 1 << CAP_LOG;
    localparam int AW      = CAP_LOG;
    localparam int HALF    = CAP / 2;
    localparam int TW_AW   = (CAP_LOG > 1) ? CAP_LOG - 1 : 1;
    localparam int SW      = $clog2(CAP_LOG + 1);
    localparam int DW      = r2fft_pkg::DATA_W;
    localparam int TWB     = r2fft_pkg::TW_BITS;
    localparam int PW      = DW + TWB;        // product width
    localparam int RW      = PW + 1 - r2fft_pkg::TW_FRAC; // rounded sum width
    localparam real TW_STEP = 2.0 * r2fft_pkg::PI_VALUE / CAP;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_MUL, ST_ADD, ST_WR_A, ST_WR_B
    } state_t;

    // ------------------------------------------------------------------
    // Twiddle ROM
    // ------------------------------------------------------------------
    logic signed [TWB-1:0] rom_cos [HALF];
    logic signed [TWB-1:0] rom_sin [HALF];

    for (genvar g = 0; g < HALF; g++) begin : g_rom
        assign rom_cos[g] = r2fft_pkg::twiddle_cos(TW_STEP, g);
        assign rom_sin[g] = r2fft_pkg::twiddle_sin(TW_STEP, g);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg;
    logic [3:0]        log_size_reg;
    logic              direction_reg;
    logic [AW-1:0]     load_ptr_reg, unload_ptr_reg;
    logic              bitrev_reg;        // reorder pass vs butterfly pass
    logic [AW-1:0]     cnt_reg;           // index in reorder, butterfly number
    logic [SW-1:0]     stage_reg;
    logic              rd_pend_reg, pend_last_reg;
    logic              m_valid_reg, m_last_reg;
    logic [63:0]       m_data_reg;
    logic [63:0]       rdata_reg;
    logic [63:0]       a_reg;
    logic [63:0]       wb_reg;            // second write of a pair
    logic signed [TWB-1:0] wr_reg, wi_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [RW-1:0]  tr_reg, ti_reg;

    // ------------------------------------------------------------------
    // Sizes and addresses
    // ------------------------------------------------------------------
    logic [4:0]    log_eff;
    logic [AW-1:0] n_mask, half_mask, half_bit, idx_p, idx_q, idx_rev, rev_full;
    logic [TW_AW-1:0] tw_idx;
    logic          last_index, last_bfly, last_stage, swap_needed;

    always_comb begin
        log_eff    = (5'(log_size_reg) > 5'(CAP_LOG)) ? 5'(CAP_LOG) : 5'(log_size_reg);
        n_mask     = ~({AW{1'b1}} << log_eff);
        half_mask  = ~({AW{1'b1}} << stage_reg);
        half_bit   = AW'(1) << stage_reg;
        idx_p      = ((cnt_reg & ~half_mask) << 1) | (cnt_reg & half_mask);
        idx_q      = idx_p | half_bit;
        tw_idx     = TW_AW'((cnt_reg & half_mask) << (AW - 1 - int'(stage_reg)));
        for (int b = 0; b < AW; b++) begin
            rev_full[b] = cnt_reg[AW-1-b];
        end
        idx_rev     = rev_full >> (5'(AW) - log_eff);
        swap_needed = cnt_reg < idx_rev;
        last_index  = cnt_reg == n_mask;
        last_bfly   = cnt_reg == (n_mask >> 1);
        last_stage  = 5'(stage_reg) + 5'd1 >= log_eff;
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_fire, load_fire, unload_fire;

    assign s_tready    = (state_reg == ST_IDLE) && !rd_pend_reg && (!m_valid_reg || m_tready);
    assign in_fire     = s_tvalid && s_tready;
    assign load_fire   = in_fire && (s_tuser == r2fft_pkg::MODE_LOAD);
    assign unload_fire = in_fire && (s_tuser == r2fft_pkg::MODE_UNLOAD);
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tlast     = m_last_reg;

    // ------------------------------------------------------------------
    // Butterfly arithmetic
    // ------------------------------------------------------------------
    logic signed [DW-1:0]  a_re, a_im, b_re, b_im;
    logic signed [PW:0]    sum_re, sum_im;
    logic signed [DW+RW:0] x_re, x_im, y_re, y_im;
    logic signed [TWB-1:0] tw_cos_sel, tw_sin_sel;

    function automatic logic [DW-1:0] sat32(input logic signed [DW+RW:0] v);
        if (v > (DW+RW+1)'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            return {1'b0, {(DW-1){1'b1}}};
        end else if (v < -(DW+RW+1)'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
            return {1'b1, {(DW-1){1'b0}}};
        end
        return v[DW-1:0];
    endfunction

    always_comb begin
        a_re   = a_reg[31:0];
        a_im   = a_reg[63:32];
        b_re   = rdata_reg[31:0];
        b_im   = rdata_reg[63:32];
        sum_re = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg) + (PW+1)'(65536);
        sum_im = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg) + (PW+1)'(65536);
        x_re   = (DW+RW+1)'(a_re) + (DW+RW+1)'(tr_reg);
        x_im   = (DW+RW+1)'(a_im) + (DW+RW+1)'(ti_reg);
        y_re   = (DW+RW+1)'(a_re) - (DW+RW+1)'(tr_reg);
        y_im   = (DW+RW+1)'(a_im) - (DW+RW+1)'(ti_reg);
        tw_cos_sel = rom_cos[tw_idx];
        tw_sin_sel = rom_sin[tw_idx];
    end

    // ------------------------------------------------------------------
    // Sample memory
    // ------------------------------------------------------------------
    logic [63:0]   mem [CAP];
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [63:0]   wdata;

    always_comb begin
        raddr = unload_ptr_reg & n_mask;
        we    = 1'b0;
        waddr = load_ptr_reg & n_mask;
        wdata = {{(DW-16){s_tdata[31]}}, s_tdata[31:16],
                 {(DW-16){s_tdata[15]}}, s_tdata[15:0]};
        case (state_reg)
            ST_IDLE: begin
                we = load_fire;
            end
            ST_RD_A: begin
                raddr = bitrev_reg ? cnt_reg : idx_p;
            end
            // hold the second address so a swap still has it in WR_A
            ST_RD_B, ST_MUL: begin
                raddr = bitrev_reg ? idx_rev : idx_q;
            end
            ST_WR_A: begin
                we    = 1'b1;
                waddr = bitrev_reg ? cnt_reg : idx_p;
                wdata = bitrev_reg ? rdata_reg
                                   : {sat32(x_im), sat32(x_re)};
            end
            ST_WR_B: begin
                we    = 1'b1;
                waddr = bitrev_reg ? idx_rev : idx_q;
                wdata = wb_reg;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_RD_B: begin
                a_reg  <= rdata_reg;     // hold first operand
                wr_reg <= tw_cos_sel;
                wi_reg <= direction_reg ? -tw_sin_sel : tw_sin_sel;
            end
            ST_MUL: begin
                p_rr_reg <= PW'(b_re) * PW'(wr_reg);
                p_ii_reg <= PW'(b_im) * PW'(wi_reg);
                p_ri_reg <= PW'(b_re) * PW'(wi_reg);
                p_ir_reg <= PW'(b_im) * PW'(wr_reg);
            end
            ST_ADD: begin
                tr_reg <= RW'(sum_re >>> r2fft_pkg::TW_FRAC);
                ti_reg <= RW'(sum_im >>> r2fft_pkg::TW_FRAC);
            end
            ST_WR_A: begin
                wb_reg <= bitrev_reg ? a_reg : {sat32(y_im), sat32(y_re)};
            end
            default: begin
                wb_reg <= wb_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control: state, pointers, output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            log_size_reg   <= 4'd10;
            direction_reg  <= 1'b0;
            load_ptr_reg   <= '0;
            unload_ptr_reg <= '0;
            bitrev_reg     <= 1'b0;
            cnt_reg        <= '0;
            stage_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            pend_last_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            // config writes
            if (cfg_we) begin
                if (cfg_index == r2fft_pkg::CFG_LOG_SIZE) begin
                    log_size_reg <= cfg_data;
                end else begin
                    direction_reg <= cfg_data[0];
                end
            end

            // drop output once taken, refill from pending read
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (rd_pend_reg) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= rdata_reg;
                m_last_reg  <= pend_last_reg;
                rd_pend_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (unload_fire) begin
                        rd_pend_reg    <= 1'b1;
                        pend_last_reg  <= (unload_ptr_reg & n_mask) == n_mask;
                        unload_ptr_reg <= ((unload_ptr_reg & n_mask) + AW'(1)) & n_mask;
                    end
                    if (load_fire) begin
                        if (s_tlast) begin
                            load_ptr_reg   <= '0;
                            unload_ptr_reg <= '0;
                            bitrev_reg     <= 1'b1;
                            cnt_reg        <= '0;
                            stage_reg      <= '0;
                            state_reg      <= ST_RD_A;
                        end else begin
                            load_ptr_reg <= ((load_ptr_reg & n_mask) + AW'(1)) & n_mask;
                        end
                    end
                end
                ST_RD_A: begin
                    if (bitrev_reg && !swap_needed) begin
                        // advance without a swap
                        if (last_index) begin
                            bitrev_reg <= 1'b0;
                            cnt_reg    <= '0;
                            state_reg  <= (log_eff == 5'd0) ? ST_IDLE : ST_RD_A;
                        end else begin
                            cnt_reg <= cnt_reg + AW'(1);
                        end
                    end else begin
                        state_reg <= ST_RD_B;
                    end
                end
                ST_RD_B: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= bitrev_reg ? ST_WR_A : ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_WR_A;
                end
                ST_WR_A: begin
                    state_reg <= ST_WR_B;
                end
                ST_WR_B: begin
                    if (bitrev_reg) begin
                        if (last_index) begin
                            bitrev_reg <= 1'b0;
                            cnt_reg    <= '0;
                            state_reg  <= (log_eff == 5'd0) ? ST_IDLE : ST_RD_A;
                        end else begin
                            cnt_reg   <= cnt_reg + AW'(1);
                            state_reg <= ST_RD_A;
                        end
                    end else if (last_bfly) begin
                        cnt_reg <= '0;
                        if (last_stage) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            stage_reg <= stage_reg + SW'(1);
                            state_reg <= ST_RD_A;
                        end
                    end else begin
                        cnt_reg   <= cnt_reg + AW'(1);
                        state_reg <= ST_RD_A;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input accepted outside idle");

    a_pend_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |=> m_valid_reg)
        else $error("pending read did not reach output");

    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_IDLE)
        else $error("read pending during transform");

    a_final_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_fire && s_tlast) |=> (state_reg == ST_RD_A && bitrev_reg))
        else $error("final load did not start reorder");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radix-2 complex FFT. A directed table covers
// pass-through, the two-point extremes, direction, wrap and early unloads;
// random frames of mostly small sizes follow. Every result transaction is
// compared against an in-bench fixed-point FFT model or a typed table value.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS    = 1024;
    localparam int POINT_LOG = 10;
    localparam int ITEMS     = 1600;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
    } bin_t;

    typedef struct {
        bit          is_cfg;
        logic [3:0]  lg;
        logic        dir;
        logic        mode;
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
        bit          typed;
        bin_t        bin;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    radix2_complex_fft uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // FFT model state
    logic signed [31:0] fft_re [POINTS];
    logic signed [31:0] fft_im [POINTS];
    int                 tw_cos [POINTS/2];
    int                 tw_sin [POINTS/2];
    bit                 written [POINTS];
    int                 load_ptr;
    int                 unload_ptr;
    int                 cur_lg;
    bit                 cur_dir;

    bin_t bins_due [$];
    row_t dir_tab  [$];
    int   errors;
    int   sender_idle;
    int   recv_stall;
    int   hold_left;
    int   sent;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int rnd_q17(input real v);
        real s;
        s = v * 131072.0;
        if (s >= 0.0)
            return $rtoi($floor(s + 0.5));
        return -$rtoi($floor(0.5 - s));
    endfunction

    function automatic int eff_log();
        return (cur_lg > POINT_LOG) ? POINT_LOG : cur_lg;
    endfunction

    function automatic logic signed [31:0] sat32(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // In-place transform: bit reversal then butterfly stages
    function automatic void run_fft();
        int     bits;
        int     n;
        int     rev;
        int     idx;
        int     p;
        int     q;
        longint wr;
        longint wi;
        longint br;
        longint bi;
        longint ar;
        longint ai;
        longint tr;
        longint ti;
        logic signed [31:0] tmp;
        bits = eff_log();
        n = 1 << bits;
        for (int i = 0; i < n; i++) begin
            rev = 0;
            for (int b = 0; b < bits; b++)
                rev |= ((i >> b) & 1) << (bits - 1 - b);
            if (i < rev) begin
                tmp = fft_re[i]; fft_re[i] = fft_re[rev]; fft_re[rev] = tmp;
                tmp = fft_im[i]; fft_im[i] = fft_im[rev]; fft_im[rev] = tmp;
            end
        end
        for (int half = 1; half < n; half <<= 1) begin
            for (int base = 0; base < n; base += 2 * half) begin
                for (int j = 0; j < half; j++) begin
                    p = base + j;
                    q = p + half;
                    idx = j * (POINTS / (2 * half));
                    wr = tw_cos[idx];
                    wi = cur_dir ? -tw_sin[idx] : tw_sin[idx];
                    br = fft_re[q]; bi = fft_im[q];
                    ar = fft_re[p]; ai = fft_im[p];
                    tr = (br * wr - bi * wi + 65536) >>> 17;
                    ti = (br * wi + bi * wr + 65536) >>> 17;
                    fft_re[p] = sat32(ar + tr); fft_im[p] = sat32(ai + ti);
                    fft_re[q] = sat32(ar - tr); fft_im[q] = sat32(ai - ti);
                end
            end
        end
    endfunction

    // Advance the model by one accepted transaction; returns 1 on a result
    function automatic bit fft_step(input logic mode, input logic [15:0] re,
                                    input logic [15:0] im, input logic last,
                                    output bin_t bin);
        int n;
        n = 1 << eff_log();
        if (mode == r2fft_pkg::MODE_LOAD) begin
            load_ptr = load_ptr & (n - 1);
            fft_re[load_ptr] = {{16{re[15]}}, re};
            fft_im[load_ptr] = {{16{im[15]}}, im};
            written[load_ptr] = 1'b1;
            load_ptr = (load_ptr + 1) & (n - 1);
            if (last) begin
                run_fft();
                load_ptr = 0;
                unload_ptr = 0;
            end
            return 1'b0;
        end
        unload_ptr = unload_ptr & (n - 1);
        bin.re = fft_re[unload_ptr];
        bin.im = fft_im[unload_ptr];
        bin.last = (unload_ptr == n - 1);
        unload_ptr = (unload_ptr + 1) & (n - 1);
        return 1'b1;
    endfunction

    function automatic bit all_written(input int n);
        for (int i = 0; i < n; i++)
            if (!written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int busy_cycles();
        int n;
        n = 1 << eff_log();
        return 6 * n + 3 * n * eff_log() + 64;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Write both registers once the block has gone quiet
    task automatic write_cfg(input logic [3:0] lg, input logic dir);
        s_tvalid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge aclk);
        repeat (busy_cycles()) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= r2fft_pkg::CFG_LOG_SIZE;
        cfg_data  <= lg;
        @(posedge aclk);
        cfg_index <= r2fft_pkg::CFG_DIRECTION;
        cfg_data  <= {3'b000, dir};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_lg  = lg;
        cur_dir = dir;
    endtask

    // Offer one transaction, hold until accepted, then update the model
    task automatic send(input logic mode, input logic [15:0] re, input logic [15:0] im,
                        input logic last, input bit typed, input bin_t typed_bin);
        bin_t bin;
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {im, re};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (fft_step(mode, re, im, last, bin))
            bins_due.push_back(typed ? typed_bin : bin);
    endtask

    function automatic void add_row(input bit is_cfg, input logic [3:0] lg, input logic dir,
                                    input logic mode, input logic [15:0] re,
                                    input logic [15:0] im, input logic last,
                                    input bit typed, input int ere, input int eim,
                                    input logic elast);
        row_t r;
        r.is_cfg = is_cfg; r.lg = lg; r.dir = dir; r.mode = mode;
        r.re = re; r.im = im; r.last = last; r.typed = typed;
        r.bin.re = ere; r.bin.im = eim; r.bin.last = elast;
        dir_tab.push_back(r);
    endfunction

    // Receiver: random back-pressure, plus a long counted hold when asked
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        bin_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bins_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result re=%0d im=%0d last=%0b",
                             $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tlast);
            end else begin
                want = bins_due.pop_front();
                if (m_tdata[31:0] !== want.re || m_tdata[63:32] !== want.im ||
                    m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("bin mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                                 want.re, want.im, want.last,
                                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tlast);
                end
            end
        end
    end

    initial begin
        bin_t none;
        int   frame;
        int   big_left;
        int   lg;
        int   n;
        int   loads;
        int   unloads;
        logic dir;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= r2fft_pkg::CFG_LOG_SIZE;
        cfg_data  <= 4'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        s_tuser   <= r2fft_pkg::MODE_LOAD;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        errors = 0; sender_idle = 0; recv_stall = 0; hold_left = 0; sent = 0;
        load_ptr = 0; unload_ptr = 0; cur_lg = 10; cur_dir = 0;
        none = '{0, 0, 0};
        for (int k = 0; k < POINTS / 2; k++) begin
            tw_cos[k] = rnd_q17($cos(2.0 * 3.14159265358979323846 * k / POINTS));
            tw_sin[k] = rnd_q17($sin(2.0 * 3.14159265358979323846 * k / POINTS));
        end
        foreach (written[i]) written[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: pass-through, two-point extremes, direction, wrap, early unload
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h7fff, 16'h8000, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 1, 32767, -32768, 1);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 1, 1, 32767, -32768, 1);
        add_row(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h7fff, 16'h7fff, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 1, -1, -1, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 1, -65535, -65535, 1);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 1, -1, -1, 0);
        add_row(1, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h0001, 16'h0000, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h0000, 16'h4000, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h1234, 16'hfedc, 1, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 0, 0, 0, 0);
        // Partial reload then unload: reads a mix of new samples and old bins
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h5555, 16'haaaa, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++)
            add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 0, 0, 0, 0);
        // Length shrunk mid-stream: pointers fold modulo the new size
        add_row(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_LOAD, 16'h0100, 16'hff00, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, r2fft_pkg::MODE_UNLOAD, 0, 0, 0, 0, 0, 0, 0);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg)
                write_cfg(dir_tab[i].lg, dir_tab[i].dir);
            else
                send(dir_tab[i].mode, dir_tab[i].re, dir_tab[i].im, dir_tab[i].last,
                     dir_tab[i].typed, dir_tab[i].bin);
        end

        // Random frames, mostly small, at most one at 256 points
        sent = 0;
        frame = 0;
        big_left = 1;
        while (sent < ITEMS) begin
            case (frame % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 81; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 81; end
                default: begin sender_idle = 17; recv_stall = 17; end
            endcase
            case ($urandom_range(19))
                0, 1:    lg = 0;
                2, 3, 4: lg = $urandom_range(7, 5);
                5:       lg = (big_left > 0) ? 8 : 3;
                default: lg = $urandom_range(4, 1);
            endcase
            if (lg >= 8) big_left--;
            dir = 1'($urandom_range(1));
            write_cfg(4'(lg), dir);
            n = 1 << eff_log();
            // Fill the pipe while the receiver holds off
            if (frame == 4) begin
                sender_idle = 0;
                hold_left <= 400;
            end
            // Noise: unload before any transform, when every entry is defined
            if ($urandom_range(19) == 0 && all_written(n))
                for (int i = $urandom_range(3); i >= 0; i--)
                    send(r2fft_pkg::MODE_UNLOAD, 16'($urandom), 16'($urandom),
                         1'($urandom_range(1)), 0, none);
            loads = n;
            case ($urandom_range(9))
                0: loads = n + $urandom_range(3, 1);
                1: if (all_written(n)) loads = $urandom_range(n, 1);
                default: ;
            endcase
            for (int i = 0; i < loads; i++)
                send(r2fft_pkg::MODE_LOAD, pick_sample(), pick_sample(), i == loads - 1,
                     0, none);
            unloads = ($urandom_range(9) == 0) ? n + $urandom_range(3, 1) : n;
            if (frame == 4) unloads = (n < 64) ? 64 : n;
            for (int i = 0; i < unloads; i++)
                send(r2fft_pkg::MODE_UNLOAD, 16'($urandom), 16'($urandom),
                     $urandom_range(3) == 0, 0, none);
            frame++;
        end

        // Drain
        s_tvalid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/r2fft_pkg.sv
rtl/radix2_complex_fft.sv
sim/testbench.sv
